### rtl/odd_pkg.sv
// Shared definitions for the occupancy dilate/downsample block: field widths,
// operation codes, configuration register indexes and reset values.
// No dependencies.
`timescale 1ns / 1ps

package odd_pkg;

	localparam int MAX_IMAGE_SIDE_DEF = 256;
	localparam int GRID_SIDE_DEF      = 64;

	localparam int OP_W       = 2;
	localparam int COORD_W    = 8;
	localparam int COLOR_W    = 8;
	localparam int ROW_W      = 6;
	localparam int CELLS_W    = 64;
	localparam int SIDE_W     = 9;
	localparam int DIL_W      = 5;
	localparam int SCALE_W    = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;
	localparam int S_DATA_W   = 48;
	localparam int M_DATA_W   = 72;

	localparam logic [OP_W-1:0] OP_PIXEL = 2'd0;
	localparam logic [OP_W-1:0] OP_READ  = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DILATE_HALF  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CELL_SCALE   = 2'd3;

	localparam logic [SIDE_W-1:0]  IMAGE_SIDE_RST = 9'd256;
	localparam logic [DIL_W-1:0]   DILATE_RST     = 5'd2;
	localparam logic [SCALE_W-1:0] SCALE_RST      = 2'd2;
	localparam logic [SCALE_W-1:0] SCALE_COARSE   = 2'd3;

endpackage

### rtl/occupancy_dilate_downsample_core.sv
// Occupancy grid builder: obstacle dilation and block-OR downsampling into a
// row-organized grid memory with read-modify-write update.
// Depends on odd_pkg.
`timescale 1ns / 1ps

// Usage
//   s_* channel: one word per item. s_tuser is the opcode (pixel, read row,
//   clear). A pixel whose red, green and blue are zero marks all grid cells
//   under its dilation square; other pixels change nothing.
//   m_* channel: one word per read-row item: the row number, its cell bits
//   masked to the grid width, and m_tuser set when the row is inside the grid.
//   cfg_*: register writes, only while the block is idle.
// Sequencing
//   Clear and ignored items leave the block idle. A read item does one memory
//   read, then the output register load. An obstacle pixel goes through accept,
//   window clipping and cell range, then a read and an OR-and-write through
//   the single-port row memory for each grid row it touches.
// Reset and stall
//   Reset restores the register defaults and marks every grid row free through
//   per-row valid bits, so no clearing pass is needed; a clear item marks the
//   rows free the same way. The output register keeps its word while m_tready is
//   low; further items are still accepted, and only a second read waits.
module occupancy_dilate_downsample_core
	import odd_pkg::*;
#(
	parameter int MAX_IMAGE_SIDE = MAX_IMAGE_SIDE_DEF,
	parameter int GRID_SIDE      = GRID_SIDE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// pixel_x[7:0], pixel_y[15:8], red[23:16], green[31:24], blue[39:32],
	// read_row[45:40], zero pad[47:46]
	input  logic [S_DATA_W-1:0]   s_tdata,
	// opcode[1:0]
	input  logic [OP_W-1:0]       s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// row_number[5:0], row_cells[69:6], zero pad[71:70]
	output logic [M_DATA_W-1:0]   m_tdata,
	// row_in_grid[0]
	output logic                  m_tuser
);

	localparam int AW = $clog2(GRID_SIDE);
	localparam int GW = $clog2(GRID_SIDE + 1);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_CLIP = 6'b000010,
		ST_CELL = 6'b000100,
		ST_RD   = 6'b001000,
		ST_WR   = 6'b010000,
		ST_ROW  = 6'b100000
	} state_t;

	function automatic logic [SIDE_W-1:0] to_cell(input logic [SIDE_W-1:0] v,
			input logic coarse);
		return coarse ? (v >> 3) : (v >> 2);
	endfunction

	state_t state_q;

	logic [SIDE_W-1:0]  width_q;
	logic [SIDE_W-1:0]  height_q;
	logic [DIL_W-1:0]   dilate_q;
	logic [SCALE_W-1:0] scale_q;

	logic [SIDE_W-1:0] eff_w;
	logic [SIDE_W-1:0] eff_h;
	logic              coarse;
	logic [SIDE_W-1:0] gw_raw;
	logic [SIDE_W-1:0] gh_raw;
	logic [GW-1:0]     grid_w;
	logic [GW-1:0]     grid_h;

	logic [COORD_W-1:0] px_q;
	logic [COORD_W-1:0] py_q;
	logic [COORD_W-1:0] x0_s1;
	logic [COORD_W-1:0] y0_s1;
	logic [SIDE_W-1:0]  x1_s1;
	logic [SIDE_W-1:0]  y1_s1;
	logic               hit_s1;

	logic [GRID_SIDE-1:0] mask_q;
	logic [AW-1:0]        row_q;
	logic [AW-1:0]        row_last_q;
	logic [ROW_W-1:0]     rd_row_q;

	logic [GRID_SIDE-1:0] mem [GRID_SIDE];
	logic [GRID_SIDE-1:0] valid_q;
	logic [GRID_SIDE-1:0] rdata_s1;
	logic                 rvalid_s1;
	logic                 mem_re;
	logic [AW-1:0]        mem_ra;
	logic                 mem_we;
	logic [GRID_SIDE-1:0] mem_wd;

	logic                 in_acc;
	logic                 dark;
	logic [ROW_W-1:0]     in_row;
	logic                 out_load;

	logic [COORD_W-1:0]   x0_c;
	logic [COORD_W-1:0]   y0_c;
	logic [SIDE_W-1:0]    xs_c;
	logic [SIDE_W-1:0]    ys_c;
	logic [SIDE_W-1:0]    x1_c;
	logic [SIDE_W-1:0]    y1_c;
	logic                 in_img;

	logic [SIDE_W-1:0]    cx0;
	logic [SIDE_W-1:0]    cx1;
	logic [SIDE_W-1:0]    cy0;
	logic [SIDE_W-1:0]    cy1;
	logic [SIDE_W-1:0]    cx1c;
	logic [SIDE_W-1:0]    cy1c;
	logic                 skip;
	logic [GRID_SIDE-1:0] mask_c;

	logic                 row_inside;
	logic [GRID_SIDE-1:0] wmask;
	logic [GRID_SIDE-1:0] row_bits;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= IMAGE_SIDE_RST;
			height_q <= IMAGE_SIDE_RST;
			dilate_q <= DILATE_RST;
			scale_q  <= SCALE_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:  width_q  <= cfg_wdata;
				CFG_IMAGE_HEIGHT: height_q <= cfg_wdata;
				CFG_DILATE_HALF:  dilate_q <= cfg_wdata[DIL_W-1:0];
				CFG_CELL_SCALE:   scale_q  <= cfg_wdata[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		eff_w  = (32'(width_q) > MAX_IMAGE_SIDE) ? SIDE_W'(MAX_IMAGE_SIDE) : width_q;
		eff_h  = (32'(height_q) > MAX_IMAGE_SIDE) ? SIDE_W'(MAX_IMAGE_SIDE) : height_q;
		coarse = (scale_q == SCALE_COARSE);
		gw_raw = to_cell(eff_w, coarse);
		gh_raw = to_cell(eff_h, coarse);
		grid_w = (32'(gw_raw) > GRID_SIDE) ? GW'(GRID_SIDE) : GW'(gw_raw);
		grid_h = (32'(gh_raw) > GRID_SIDE) ? GW'(GRID_SIDE) : GW'(gh_raw);
	end

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign dark     = (s_tdata[23:16] == '0) && (s_tdata[31:24] == '0)
		&& (s_tdata[39:32] == '0);
	assign in_row   = s_tdata[45:40];
	assign out_load = (state_q == ST_ROW) && (!m_tvalid || m_tready);

	// window clipping
	always_comb begin
		in_img = ({1'b0, px_q} < eff_w) && ({1'b0, py_q} < eff_h);
		x0_c   = (px_q > COORD_W'(dilate_q)) ? (px_q - COORD_W'(dilate_q)) : '0;
		y0_c   = (py_q > COORD_W'(dilate_q)) ? (py_q - COORD_W'(dilate_q)) : '0;
		xs_c   = {1'b0, px_q} + SIDE_W'(dilate_q);
		ys_c   = {1'b0, py_q} + SIDE_W'(dilate_q);
		x1_c   = (xs_c > eff_w - 1'b1) ? (eff_w - 1'b1) : xs_c;
		y1_c   = (ys_c > eff_h - 1'b1) ? (eff_h - 1'b1) : ys_c;
	end

	// cell range and column mask
	always_comb begin
		cx0  = to_cell({1'b0, x0_s1}, coarse);
		cy0  = to_cell({1'b0, y0_s1}, coarse);
		cx1  = to_cell(x1_s1, coarse);
		cy1  = to_cell(y1_s1, coarse);
		skip = !hit_s1 || (cx0 >= SIDE_W'(grid_w)) || (cy0 >= SIDE_W'(grid_h));
		cx1c = (cx1 > SIDE_W'(grid_w) - 1'b1) ? (SIDE_W'(grid_w) - 1'b1) : cx1;
		cy1c = (cy1 > SIDE_W'(grid_h) - 1'b1) ? (SIDE_W'(grid_h) - 1'b1) : cy1;
		for (int c = 0; c < GRID_SIDE; c++) begin
			mask_c[c] = (SIDE_W'(c) >= cx0) && (SIDE_W'(c) <= cx1c);
		end
	end

	// read result
	always_comb begin
		row_inside = (32'(rd_row_q) < 32'(grid_h));
		for (int c = 0; c < GRID_SIDE; c++) begin
			wmask[c] = (GW'(c) < grid_w);
		end
		row_bits = (rvalid_s1 ? rdata_s1 : '0) & wmask;
	end

	// memory port control
	always_comb begin
		mem_re = 1'b0;
		mem_ra = row_q;
		if (state_q == ST_IDLE) begin
			mem_re = in_acc && (s_tuser == OP_READ);
			mem_ra = in_row[AW-1:0];
		end else if (state_q == ST_RD) begin
			mem_re = 1'b1;
		end
		mem_we = (state_q == ST_WR);
		mem_wd = (rvalid_s1 ? rdata_s1 : '0) | mask_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[row_q] <= mem_wd;
		end
		if (mem_re) begin
			rdata_s1  <= mem[mem_ra];
			rvalid_s1 <= valid_q[mem_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (in_acc && (s_tuser == OP_CLEAR)) begin
			valid_q <= '0;
		end else if (mem_we) begin
			valid_q[row_q] <= 1'b1;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc && (s_tuser == OP_PIXEL) && dark) begin
						state_q <= ST_CLIP;
					end else if (in_acc && (s_tuser == OP_READ)) begin
						state_q <= ST_ROW;
					end
				end
				ST_CLIP: state_q <= ST_CELL;
				ST_CELL: state_q <= skip ? ST_IDLE : ST_RD;
				ST_RD:   state_q <= ST_WR;
				ST_WR:   state_q <= (row_q == row_last_q) ? ST_IDLE : ST_RD;
				ST_ROW:  state_q <= out_load ? ST_IDLE : ST_ROW;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			px_q     <= s_tdata[7:0];
			py_q     <= s_tdata[15:8];
			rd_row_q <= in_row;
		end
		if (state_q == ST_CLIP) begin
			x0_s1  <= x0_c;
			y0_s1  <= y0_c;
			x1_s1  <= x1_c;
			y1_s1  <= y1_c;
			hit_s1 <= in_img;
		end
		if (state_q == ST_CELL) begin
			mask_q     <= mask_c;
			row_q      <= cy0[AW-1:0];
			row_last_q <= cy1c[AW-1:0];
		end else if (state_q == ST_WR) begin
			row_q <= row_q + 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata <= {2'b00, (row_inside ? CELLS_W'(row_bits) : {CELLS_W{1'b0}}), rd_row_q};
			m_tuser <= row_inside;
		end
	end

endmodule

### rtl/odd_checker.sv
// Port-level checks for occupancy_dilate_downsample_core, bound to the top.
// Depends on odd_pkg.
`timescale 1ns / 1ps

module odd_checker
	import odd_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic [S_DATA_W-1:0] s_tdata,
	input logic [OP_W-1:0]     s_tuser,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata,
	input logic                m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("output word changed while stalled");

	// rows outside the grid report no blocked cells
	a_outside_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[69:6] == '0)
		else $error("out-of-grid row carries cell bits");

	// an obstacle pixel or a row read keeps the input closed for the next cycle
	a_busy_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == OP_READ
		|| (s_tuser == OP_PIXEL && s_tdata[39:16] == '0)) |=> !s_tready)
		else $error("input accepted while update or read in progress");

endmodule

bind occupancy_dilate_downsample_core odd_checker u_odd_checker (.*);

### verif/tb_occupancy_dilate_downsample_core.sv
// Self-checking testbench for occupancy_dilate_downsample_core: directed and random
// pixel, read-row and clear words, with each returned grid row checked against a
// grid kept here. Depends on odd_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_occupancy_dilate_downsample_core;
	import odd_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_WORDS   = 142;

	typedef struct packed {
		logic [1:0]         pad;
		logic [ROW_W-1:0]   read_row;
		logic [COLOR_W-1:0] blue;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] red;
		logic [COORD_W-1:0] pixel_y;
		logic [COORD_W-1:0] pixel_x;
	} pixel_word_t;

	typedef struct packed {
		logic [1:0]         pad;
		logic [CELLS_W-1:0] row_cells;
		logic [ROW_W-1:0]   row_number;
	} row_word_t;

	typedef struct packed {
		logic      in_grid;
		row_word_t word;
	} grid_row_t;

	class grid_scoreboard;
		logic [CELLS_W-1:0] grid [GRID_SIDE_DEF];
		logic [SIDE_W-1:0]  img_w;
		logic [SIDE_W-1:0]  img_h;
		logic [DIL_W-1:0]   radius;
		logic [SCALE_W-1:0] scale;
		grid_row_t          pending_rows[$];
		int                 errors;

		function new();
			foreach (grid[i])
				grid[i] = '0;
			img_w  = IMAGE_SIDE_RST;
			img_h  = IMAGE_SIDE_RST;
			radius = DILATE_RST;
			scale  = SCALE_RST;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_IMAGE_WIDTH: begin
					img_w = val[SIDE_W-1:0];
				end
				CFG_IMAGE_HEIGHT: begin
					img_h = val[SIDE_W-1:0];
				end
				CFG_DILATE_HALF: begin
					radius = val[DIL_W-1:0];
				end
				CFG_CELL_SCALE: begin
					scale = val[SCALE_W-1:0];
				end
			endcase
		endfunction

		function int eff_side(logic [SIDE_W-1:0] v);
			return (v > MAX_IMAGE_SIDE_DEF) ? MAX_IMAGE_SIDE_DEF : int'(v);
		endfunction

		function int eff_scale();
			return (scale < 2) ? 2 : int'(scale);
		endfunction

		function int grid_dim(logic [SIDE_W-1:0] side);
			int g;
			g = eff_side(side) >> eff_scale();
			return (g > GRID_SIDE_DEF) ? GRID_SIDE_DEF : g;
		endfunction

		function logic [CELLS_W-1:0] low_mask(int n);
			if (n >= CELLS_W)
				return '1;
			return (64'd1 << n) - 64'd1;
		endfunction

		function void mark_obstacle(int x, int y);
			int w, h, s, gw, gh, d;
			int x0, x1, y0, y1, cx0, cx1, cy0, cy1;
			logic [CELLS_W-1:0] bits;
			w  = eff_side(img_w);
			h  = eff_side(img_h);
			s  = eff_scale();
			gw = grid_dim(img_w);
			gh = grid_dim(img_h);
			d  = int'(radius);
			if (x >= w || y >= h)
				return;
			x0 = (x > d) ? x - d : 0;
			y0 = (y > d) ? y - d : 0;
			x1 = (x + d > w - 1) ? w - 1 : x + d;
			y1 = (y + d > h - 1) ? h - 1 : y + d;
			cx0 = x0 >> s;
			cx1 = x1 >> s;
			cy0 = y0 >> s;
			cy1 = y1 >> s;
			if (cx0 >= gw || cy0 >= gh)
				return;
			if (cx1 > gw - 1)
				cx1 = gw - 1;
			if (cy1 > gh - 1)
				cy1 = gh - 1;
			bits = low_mask(cx1 + 1) & ~low_mask(cx0);
			for (int r = cy0; r <= cy1; r++)
				grid[r] |= bits;
		endfunction

		function void note_item(logic [OP_W-1:0] op, pixel_word_t w);
			grid_row_t exp_row;
			int gw, gh;
			case (op)
				OP_PIXEL: begin
					if (w.red == '0 && w.green == '0 && w.blue == '0)
						mark_obstacle(int'(w.pixel_x), int'(w.pixel_y));
				end
				OP_READ: begin
					gw = grid_dim(img_w);
					gh = grid_dim(img_h);
					exp_row = '0;
					exp_row.word.row_number = w.read_row;
					exp_row.in_grid = (int'(w.read_row) < gh);
					if (exp_row.in_grid)
						exp_row.word.row_cells = grid[w.read_row] & low_mask(gw);
					pending_rows.push_back(exp_row);
				end
				OP_CLEAR: begin
					foreach (grid[i])
						grid[i] = '0;
				end
				default: begin
				end
			endcase
		endfunction

		function void check_row(row_word_t got, logic got_in_grid);
			grid_row_t exp_row;
			if (pending_rows.size() == 0) begin
				$error("unexpected row word: row_number %0d", got.row_number);
				errors++;
				return;
			end
			exp_row = pending_rows.pop_front();
			if (got.row_number !== exp_row.word.row_number) begin
				$error("row_number: expected %0d, got %0d",
					exp_row.word.row_number, got.row_number);
				errors++;
			end
			if (got.row_cells !== exp_row.word.row_cells) begin
				$error("row_cells: expected %h, got %h",
					exp_row.word.row_cells, got.row_cells);
				errors++;
			end
			if (got_in_grid !== exp_row.in_grid) begin
				$error("row_in_grid: expected %0d, got %0d", exp_row.in_grid, got_in_grid);
				errors++;
			end
			if (got.pad !== '0) begin
				$error("pad: expected 0, got %0d", got.pad);
				errors++;
			end
		endfunction

		function int pending();
			return pending_rows.size();
		endfunction
	endclass

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata   = '0;
	logic [OP_W-1:0]       s_tuser   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [M_DATA_W-1:0]   m_tdata;
	logic                  m_tuser;

	grid_scoreboard sb = new();
	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;
	int rx_stall = 0;
	int cycles = 0;

	occupancy_dilate_downsample_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("occupancy_dilate_downsample_core regression: fail");
			$finish;
		end
	end

	function automatic int pick_gap(bit idle_on);
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// row word sink with random back-pressure
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_row(row_word_t'(m_tdata), m_tuser);
		if (rx_stall > 0) begin
			m_tready <= 1'b0;
			rx_stall <= rx_stall - 1;
		end else begin
			m_tready <= arst_n;
			rx_stall <= pick_gap(rx_idle);
		end
	end

	function automatic pixel_word_t make_word(int x, int y, int r, int g, int b, int row);
		pixel_word_t w;
		w = '0;
		w.pixel_x  = x[COORD_W-1:0];
		w.pixel_y  = y[COORD_W-1:0];
		w.red      = r[COLOR_W-1:0];
		w.green    = g[COLOR_W-1:0];
		w.blue     = b[COLOR_W-1:0];
		w.read_row = row[ROW_W-1:0];
		return w;
	endfunction

	task automatic send_word(logic [OP_W-1:0] op, pixel_word_t w);
		int gap;
		gap = pick_gap(tx_idle);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= w;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_item(op, w);
	endtask

	task automatic drain_rows();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_reg(idx, val[CFG_DATA_W-1:0]);
	endtask

	// pixel words give no row word, so allow the longest update to finish
	task automatic set_config(int w, int h, int d, int s);
		drain_rows();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(CFG_IMAGE_WIDTH, w);
		write_reg(CFG_IMAGE_HEIGHT, h);
		write_reg(CFG_DILATE_HALF, d);
		write_reg(CFG_CELL_SCALE, s);
	endtask

	function automatic int pick_coord(int side);
		int hi;
		if ($urandom_range(0, 4) == 0)
			return $urandom_range(0, 255);
		hi = (side > 252) ? 255 : side + 3;
		return $urandom_range(0, hi);
	endfunction

	function automatic int pick_color();
		return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 255);
	endfunction

	function automatic void random_item(output logic [OP_W-1:0] op, output pixel_word_t w);
		int r, gh, row;
		r  = $urandom_range(0, 99);
		gh = sb.grid_dim(sb.img_h);
		row = ($urandom_range(0, 9) < 7) ? $urandom_range(0, (gh > 62) ? 63 : gh + 1)
			: $urandom_range(0, 63);
		if (r < 62)
			op = OP_PIXEL;
		else if (r < 93)
			op = OP_READ;
		else if (r < 95)
			op = OP_CLEAR;
		else
			op = OP_UNUSED;
		if (op == OP_PIXEL && $urandom_range(0, 1) == 0)
			w = make_word(pick_coord(sb.eff_side(sb.img_w)),
				pick_coord(sb.eff_side(sb.img_h)), 0, 0, 0, row);
		else
			w = make_word(pick_coord(sb.eff_side(sb.img_w)),
				pick_coord(sb.eff_side(sb.img_h)), pick_color(), pick_color(),
				pick_color(), row);
	endfunction

	task automatic run_random(int n);
		logic [OP_W-1:0] op;
		pixel_word_t w;
		int count;
		count = 0;
		while (count < n) begin
			random_item(op, w);
			send_word(op, w);
			if (op != OP_UNUSED) begin
				count++;
				if (count == n / 2)
					drain_rows();
			end
		end
	endtask

	int phase_w [RANDOM_PHASES] = '{256, 64, 511, 1, 37, 256, 0, 130};
	int phase_h [RANDOM_PHASES] = '{256, 48, 511, 1, 200, 17, 256, 90};
	int phase_d [RANDOM_PHASES] = '{2, 0, 31, 0, 5, 17, 3, 9};
	int phase_s [RANDOM_PHASES] = '{2, 3, 3, 0, 1, 2, 2, 2};

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: corners, color channels, unused opcode, clear
		send_word(OP_READ, make_word(0, 0, 0, 0, 0, 0));
		send_word(OP_PIXEL, make_word(0, 0, 0, 0, 0, 0));
		send_word(OP_PIXEL, make_word(255, 255, 0, 0, 0, 0));
		send_word(OP_PIXEL, make_word(128, 64, 255, 0, 0, 0));
		send_word(OP_PIXEL, make_word(128, 64, 0, 255, 0, 0));
		send_word(OP_PIXEL, make_word(128, 64, 0, 0, 255, 0));
		send_word(OP_PIXEL, make_word(255, 255, 255, 255, 255, 63));
		send_word(OP_UNUSED, make_word(255, 255, 255, 255, 255, 63));
		send_word(OP_READ, make_word(0, 0, 0, 0, 0, 0));
		send_word(OP_READ, make_word(0, 0, 0, 0, 0, 63));
		send_word(OP_READ, make_word(0, 0, 0, 0, 0, 32));
		send_word(OP_CLEAR, make_word(0, 0, 0, 0, 0, 0));
		send_word(OP_READ, make_word(0, 0, 0, 0, 0, 0));

		// oversized image saturates, scale 0 acts as 2, widest window
		set_config(511, 300, 31, 0);
		send_word(OP_PIXEL, make_word(100, 100, 0, 0, 0, 0));
		send_word(OP_READ, make_word(0, 0, 0, 0, 0, 17));
		send_word(OP_READ, make_word(0, 0, 0, 0, 0, 33));

		// narrower grid hides stale columns; off-image pixel; row past grid
		set_config(40, 200, 2, 1);
		send_word(OP_READ, make_word(0, 0, 0, 0, 0, 17));
		send_word(OP_READ, make_word(0, 0, 0, 0, 0, 55));
		send_word(OP_PIXEL, make_word(50, 5, 0, 0, 0, 0));
		send_word(OP_PIXEL, make_word(39, 199, 0, 0, 0, 0));
		send_word(OP_READ, make_word(0, 0, 0, 0, 0, 49));

		// zero-size image: empty grid
		set_config(0, 0, 0, 3);
		send_word(OP_PIXEL, make_word(0, 0, 0, 0, 0, 0));
		send_word(OP_READ, make_word(0, 0, 0, 0, 0, 0));

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			set_config(phase_w[p], phase_h[p], phase_d[p], phase_s[p]);
			tx_idle = (p % 3 != 1);
			rx_idle = (p % 4 != 2);
			run_random(PHASE_WORDS);
		end

		drain_rows();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("occupancy_dilate_downsample_core regression: pass");
		else
			$display("occupancy_dilate_downsample_core regression: fail");
		$finish;
	end

endmodule
